// ===== rtl/core/length_prefix_deframer_unit_assert.svh =====
// Assertion macros shared by the deframer checker.
`ifndef LENGTH_PREFIX_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIX_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define LPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked during reset as well.
`define LPD_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lpd_pkg.sv =====
// Package with the types and constants of the length-prefix deframer.
package lpd_pkg;

   localparam int LEN_W  = 32;
   localparam int BYTE_W = 8;
   localparam int FILL_W = 3;
   localparam int IDX_W  = 2;

   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'd10000000;

   // Configuration port geometry: one 32-bit register at word address zero.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_MAX_LENGTH_IDX = 1'b0;

   // Kinds of queue entries.
   localparam logic ENTRY_PAYLOAD = 1'b0;
   localparam logic ENTRY_HEADER  = 1'b1;

   // One queue entry: a whole header (several result transactions) or one payload byte.
   typedef struct packed {
      logic             kind;
      logic             last;
      logic [LEN_W-1:0] word;
      logic [LEN_W-1:0] length;
   } entry_type;

endpackage

// ===== rtl/core/lpd_front.sv =====
// Front end: header hunting window, length check and payload byte count.
module lpd_front #(
   parameter int HEADER_BYTES = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_valid,
   output logic                     byte_ready,
   input  logic [lpd_pkg::BYTE_W-1:0] data_byte,
   input  logic [lpd_pkg::LEN_W-1:0]  max_length,
   input  logic                     queue_full,
   output logic                     push,
   output lpd_pkg::entry_type       push_entry
);
   import lpd_pkg::*;

   localparam int WIN_W = 8 * HEADER_BYTES;
   localparam logic [WIN_W-1:0] KEEP_MASK = {WIN_W{1'b1}} >> 8;
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(HEADER_BYTES);
   localparam logic [FILL_W-1:0] DROP_FILL = FILL_W'(HEADER_BYTES - 1);

   logic [WIN_W-1:0]        win_ff, win_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic                    inpay_ff, inpay_in;
   logic [LEN_W-1:0]        rem_ff, rem_in;
   logic [LEN_W-1:0]        cur_ff, cur_in;

   logic                    accept;
   logic [WIN_W+7:0]        win_cat;
   logic [WIN_W-1:0]        win_shift;
   logic [FILL_W-1:0]       fill_inc;
   logic [LEN_W-1:0]        hdr_len;
   logic [LEN_W-1:0]        rem_dec;
   logic                    hdr_bad;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;

   // Window shift, fill count and length decode for the hunting path.
   assign win_cat   = {win_ff, data_byte};
   assign win_shift = win_cat[WIN_W-1:0];
   assign fill_inc  = (fill_ff < FULL_FILL) ? fill_ff + 1'b1 : fill_ff;
   assign hdr_len   = LEN_W'(win_shift);
   assign hdr_bad   = (hdr_len == '0) || (hdr_len > max_length);
   assign rem_dec   = rem_ff - LEN_W'(rem_ff != '0);

   // Next state and queue entry for each accepted byte.
   always_comb begin
      win_in     = win_ff;
      fill_in    = fill_ff;
      inpay_in   = inpay_ff;
      rem_in     = rem_ff;
      cur_in     = cur_ff;
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         if (inpay_ff) begin
            rem_in            = rem_dec;
            push              = 1'b1;
            push_entry.kind   = ENTRY_PAYLOAD;
            push_entry.last   = (rem_dec == '0);
            push_entry.word   = LEN_W'(data_byte);
            push_entry.length = cur_ff;
            if (rem_dec == '0) begin
               inpay_in = 1'b0;
               win_in   = '0;
               fill_in  = '0;
            end
         end else begin
            win_in  = win_shift;
            fill_in = fill_inc;
            if (fill_inc == FULL_FILL) begin
               if (hdr_bad) begin
                  // Drop the oldest byte and keep hunting one byte later.
                  fill_in = DROP_FILL;
                  win_in  = win_shift & KEEP_MASK;
               end else begin
                  inpay_in          = 1'b1;
                  rem_in            = hdr_len;
                  cur_in            = hdr_len;
                  win_in            = '0;
                  fill_in           = '0;
                  push              = 1'b1;
                  push_entry.kind   = ENTRY_HEADER;
                  push_entry.last   = 1'b0;
                  push_entry.word   = hdr_len;
                  push_entry.length = hdr_len;
               end
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         fill_ff  <= '0;
         inpay_ff <= 1'b0;
         rem_ff   <= '0;
         cur_ff   <= '0;
      end else begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         inpay_ff <= inpay_in;
         rem_ff   <= rem_in;
         cur_ff   <= cur_in;
      end
   end

endmodule

// ===== rtl/core/lpd_queue.sv =====
// Short entry queue between the front end and the result sequencer.
module lpd_queue #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output lpd_pkg::entry_type head_entry
);
   import lpd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   entry_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/lpd_back.sv =====
// Result sequencer: expands header entries into bytes and drives the output register.
module lpd_back #(
   parameter int HEADER_BYTES = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  lpd_pkg::entry_type         head_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [lpd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_unit_first,
   output logic                       rsp_unit_last,
   output logic [lpd_pkg::LEN_W-1:0]  rsp_payload_length
);
   import lpd_pkg::*;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HEADER_BYTES - 1);

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              first_ff, first_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic              load;
   logic [IDX_W-1:0]  sel;

   // A new result transaction is loaded when the output register is empty or draining.
   assign load = head_valid && (!valid_ff || rsp_ready);
   assign sel  = IDX_LAST - idx_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      first_in = first_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         len_in   = head_entry.length;
         if (head_entry.kind == ENTRY_HEADER) begin
            // Header bytes go out most significant first.
            byte_in  = head_entry.word[{sel, 3'b000} +: BYTE_W];
            first_in = (idx_ff == '0);
            last_in  = 1'b0;
            if (idx_ff == IDX_LAST) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            byte_in  = head_entry.word[BYTE_W-1:0];
            first_in = 1'b0;
            last_in  = head_entry.last;
            pop      = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      len_ff   <= len_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_unit_first     = first_ff;
   assign rsp_unit_last      = last_ff;
   assign rsp_payload_length = len_ff;

endmodule

// ===== rtl/core/length_prefix_deframer_unit.sv =====
// Top level of the length-prefix deframer: register port and the three pipeline parts.
//
//   Port group   Direction   Carries
//   req_         in          one raw stream byte per transaction
//   rsp_         out         one unit byte with first/last flags and payload length
//   csr_         in/out      APB-style access to max_length (word address 0)
//
// The input takes one byte per cycle while the entry queue has room; a byte's result
// is presented on rsp_ once it has passed through a queue entry and the output register.
// A header becomes one queue entry that the result sequencer plays out as HEADER_BYTES
// result transactions while the payload bytes queue up behind it; QUEUE_DEPTH of
// HEADER_BYTES + 1 absorbs that burst, so a unit streams with no gap on either side.
// Reset is synchronous; there is no clearing pass.
// A stall on rsp_ready holds the output register and backs up through the queue.
module length_prefix_deframer_unit #(
   parameter int HEADER_BYTES = 4,
   parameter int QUEUE_DEPTH  = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lpd_pkg::BYTE_W-1:0]     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lpd_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_unit_first,
   output logic                           rsp_unit_last,
   output logic [lpd_pkg::LEN_W-1:0]      rsp_payload_length,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lpd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lpd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lpd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import lpd_pkg::*;

   logic [LEN_W-1:0] max_length_ff, max_length_in;
   logic             reg_sel;
   logic             csr_write;

   logic             push;
   entry_type        push_entry;
   logic             queue_full;
   logic             pop;
   logic             head_valid;
   entry_type        head_entry;

   // Register decode and write.
   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_MAX_LENGTH_IDX);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = reg_sel ? max_length_ff : '0;

   always_comb begin
      max_length_in = max_length_ff;
      if (csr_write && reg_sel) begin
         max_length_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   // Header hunting and payload counting.
   lpd_front #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid),
      .byte_ready (req_ready),
      .data_byte  (req_data_byte),
      .max_length (max_length_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   lpd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Result sequencing and output register.
   lpd_back #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_unit_first     (rsp_unit_first),
      .rsp_unit_last      (rsp_unit_last),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

// ===== rtl/core/lpd_checker.sv =====
// Port-level checker for the deframer and its bind to the top level.
`include "length_prefix_deframer_unit_assert.svh"

module lpd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [lpd_pkg::BYTE_W-1:0]     rsp_out_byte,
   input logic                           rsp_unit_first,
   input logic                           rsp_unit_last,
   input logic [lpd_pkg::LEN_W-1:0]      rsp_payload_length,
   input logic                           csr_pready
);
   import lpd_pkg::*;

   // A unit never starts and ends on the same transaction, since its header precedes the payload.
   `LPD_ASSERT_IMPLY(a_first_not_last, clock, reset, rsp_valid, !(rsp_unit_first && rsp_unit_last), "first and last flags on one result")

   // Only accepted headers reach the output, so the length is never zero.
   `LPD_ASSERT_IMPLY(a_length_nonzero, clock, reset, rsp_valid, rsp_payload_length != '0, "zero payload length on a result")

   // A stalled result keeps its byte and length.
   `LPD_ASSERT_IMPLY(a_stall_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid && $stable(rsp_out_byte) && $stable(rsp_payload_length), "stalled result changed")

   // The register port never waits.
   `LPD_ASSERT_IMPLY(a_pready_high, clock, reset, 1'b1, csr_pready, "pready dropped")

   // Reset empties the output register.
   `LPD_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")

endmodule

bind length_prefix_deframer_unit lpd_checker u_lpd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_unit_first     (rsp_unit_first),
   .rsp_unit_last      (rsp_unit_last),
   .rsp_payload_length (rsp_payload_length),
   .csr_pready         (csr_pready)
);

// ===== test/tb_length_prefix_deframer_unit.sv =====
// Self-checking testbench for the length-prefix deframer: directed rows, random phases, APB setup.
`timescale 1ns / 100ps

module tb_length_prefix_deframer_unit;
   import lpd_pkg::*;

   localparam int UNIT_HDR_BYTES = 4;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TAIL_CYCLES    = 20;
   localparam int QUIET_LIMIT    = 2000;

   // Register addresses: max_length is register 0, the next word has no register.
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_LENGTH = CSR_ADDR_W'(4 * CSR_MAX_LENGTH_IDX);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED     = CSR_ADDR_W'(4);

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              first;
      logic              last;
      logic [LEN_W-1:0]  length;
   } unit_byte_type;

   typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [31:0]           value;
      bit                    typed;
      unit_byte_type         want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_unit_first;
   logic                  rsp_unit_last;
   logic [LEN_W-1:0]      rsp_payload_length;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predicted deframer state and the unit bytes still owed by the block.
   logic [LEN_W-1:0] max_len;
   logic [31:0]      hunt_window;
   int               hunt_fill;
   bit               in_unit;
   logic [LEN_W-1:0] unit_left;
   logic [LEN_W-1:0] unit_len;
   unit_byte_type    pending_bytes[$];
   stim_row_type     directed_rows[$];

   int errors;
   int tx_pct;
   int rx_pct;
   int quiet_cycles = 0;

   length_prefix_deframer_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_unit_first     (rsp_unit_first),
      .rsp_unit_last      (rsp_unit_last),
      .rsp_payload_length (rsp_payload_length),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the predicted state by one stream byte and queue the unit bytes it releases.
   task automatic deframe_byte(input logic [BYTE_W-1:0] b, input bit quiet);
      unit_byte_type r;
      int            i;
      if (in_unit) begin
         if (unit_left != 0) unit_left = unit_left - 1;
         r.data   = b;
         r.first  = 1'b0;
         r.last   = (unit_left == 0);
         r.length = unit_len;
         if (!quiet) pending_bytes.push_back(r);
         if (unit_left == 0) begin
            in_unit     = 1'b0;
            hunt_window = '0;
            hunt_fill   = 0;
         end
      end else begin
         hunt_window = {hunt_window[23:0], b};
         if (hunt_fill < UNIT_HDR_BYTES) hunt_fill++;
         if (hunt_fill == UNIT_HDR_BYTES) begin
            if (hunt_window == 0 || hunt_window > max_len) begin
               // Rejected header: forget the oldest byte and keep sliding.
               hunt_fill          = UNIT_HDR_BYTES - 1;
               hunt_window[31:24] = 8'h00;
            end else begin
               unit_len  = hunt_window;
               unit_left = hunt_window;
               in_unit   = 1'b1;
               for (i = 0; i < UNIT_HDR_BYTES; i++) begin
                  r.data   = hunt_window[8*(UNIT_HDR_BYTES-1-i) +: 8];
                  r.first  = (i == 0);
                  r.last   = 1'b0;
                  r.length = unit_len;
                  if (!quiet) pending_bytes.push_back(r);
               end
               hunt_window = '0;
               hunt_fill   = 0;
            end
         end
      end
   endtask

   // Offer one byte, wait for the transaction, then idle at random.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit quiet);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      deframe_byte(b, quiet);
      if ($urandom_range(0, 99) < tx_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_pct);
      end
   endtask

   task automatic send_word(input logic [31:0] w);
      int k;
      for (k = UNIT_HDR_BYTES - 1; k >= 0; k--) send_byte(w[8*k +: 8], 1'b0);
   endtask

   task automatic send_unit(input logic [31:0] len);
      send_word(len);
      repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
   endtask

   // Register access happens only once all owed bytes are out and the pipeline is quiet.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr != ADDR_MAX_LENGTH) begin
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end else begin
         max_len = value;
         // Read the limit back in a second transfer.
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== max_len) begin
            $display("%0t: max_length read back expected %h, got %h", $time, max_len,
                     csr_prdata);
            errors++;
         end
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   // Feed bytes until the block is between units with an empty header window.
   task automatic reach_unit_boundary();
      while (in_unit || hunt_fill != 0) begin
         if (in_unit)
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
         else if (hunt_fill == UNIT_HDR_BYTES - 1 && hunt_window[23:0] == 0)
            send_byte(8'h01, 1'b0);
         else
            send_byte(8'h00, 1'b0);
      end
   endtask

   // One random phase. Noisy phases run with small limits, so no accepted unit is long;
   // clean phases use short headers and zero runs, which never open a long unit.
   task automatic run_phase(input logic [31:0] lim, input int tx, input int rx,
                            input int count, input bit clean);
      int          sent;
      int          pick;
      int          n;
      logic [31:0] len;
      csr_write(ADDR_MAX_LENGTH, lim);
      tx_pct = tx;
      rx_pct = rx;
      sent   = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (clean) begin
            if (pick < 80) begin
               len = $urandom_range(1, 24);
               send_unit(len);
               sent += UNIT_HDR_BYTES + len;
            end else begin
               n = $urandom_range(1, 5);
               repeat (n) send_byte(8'h00, 1'b0);
               sent += n;
            end
         end else if (pick < 55) begin
            len = (lim == 0) ? $urandom_range(1, 8) : $urandom_range(1, lim);
            send_unit(len);
            sent += UNIT_HDR_BYTES + len;
         end else if (pick < 75) begin
            // Broken header: zero length or one above the limit, then a few stray bytes.
            len = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
            if (len != 0 && len <= lim) len = lim + 1;
            send_word(len);
            n = $urandom_range(0, 3);
            repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            sent += UNIT_HDR_BYTES + n;
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            sent += n;
         end
      end
   endtask

   function automatic void add_byte(input logic [7:0] b);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_BYTE;
      row.value = {24'h0, b};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic [7:0] b, input logic first, input logic last,
                                     input logic [31:0] len);
      stim_row_type row;
      row             = '0;
      row.kind        = ROW_BYTE;
      row.value       = {24'h0, b};
      row.typed       = 1'b1;
      row.want.data   = b;
      row.want.first  = first;
      row.want.last   = last;
      row.want.length = len;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] v);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.addr  = addr;
      row.value = v;
      directed_rows.push_back(row);
   endfunction

   // Result side: random stalls and the in-order comparison against owed bytes.
   always @(posedge clock) begin
      unit_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected result: byte %h first %b last %b length %h", $time,
                     rsp_out_byte, rsp_unit_first, rsp_unit_last, rsp_payload_length);
            errors++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               $display("%0t: out_byte expected %h, got %h", $time, want.data, rsp_out_byte);
               errors++;
            end
            if (rsp_unit_first !== want.first) begin
               $display("%0t: unit_first expected %b, got %b", $time, want.first,
                        rsp_unit_first);
               errors++;
            end
            if (rsp_unit_last !== want.last) begin
               $display("%0t: unit_last expected %b, got %b", $time, want.last, rsp_unit_last);
               errors++;
            end
            if (rsp_payload_length !== want.length) begin
               $display("%0t: payload_length expected %h, got %h", $time, want.length,
                        rsp_payload_length);
               errors++;
            end
         end
      end
      rsp_ready <= !reset && ($urandom_range(0, 99) >= rx_pct);
   end

   // Watchdog: too many cycles without any transaction ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_length_prefix_deframer_unit: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type row;
      int           i;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      errors        = 0;
      tx_pct        = 0;
      rx_pct        = 0;
      max_len       = MAX_LENGTH_RESET;
      hunt_window   = '0;
      hunt_fill     = 0;
      in_unit       = 1'b0;
      unit_left     = '0;
      unit_len      = '0;

      // Directed rows, starting from the reset limit.
      // A write to the empty register slot must leave the limit alone.
      add_write(ADDR_UNUSED, 32'd5);
      // Zero-length headers are dropped; the sliding window then finds length 2.
      add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
      add_byte(8'h00); add_byte(8'h02);
      add_typed(8'hFF, 1'b0, 1'b0, 32'd2);
      add_typed(8'h80, 1'b0, 1'b1, 32'd2);
      // One above the reset limit is rejected and the block resyncs byte by byte.
      add_byte(8'h00); add_byte(8'h98); add_byte(8'h96); add_byte(8'h81);
      add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h01);
      add_typed(8'h7E, 1'b0, 1'b1, 32'd1);
      // A limit change in the middle of a unit leaves that unit's length as it was.
      add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h03);
      add_typed(8'h55, 1'b0, 1'b0, 32'd3);
      add_write(ADDR_MAX_LENGTH, 32'd1);
      add_typed(8'hAA, 1'b0, 1'b0, 32'd3);
      add_typed(8'h01, 1'b0, 1'b1, 32'd3);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            csr_write(row.addr, row.value);
         end else begin
            if (row.typed) pending_bytes.push_back(row.want);
            send_byte(row.value[7:0], row.typed);
         end
      end

      // Random phases over the limit extremes and the idling patterns.
      run_phase(32'd1, 0, 0, 70, 1'b0);
      run_phase(32'd0, 61, 0, 30, 1'b0);
      run_phase(32'd20, 29, 29, 110, 1'b0);
      reach_unit_boundary();
      run_phase(MAX_LENGTH_RESET, 0, 61, 90, 1'b1);
      run_phase(32'hFFFF_FFFF, 29, 29, 90, 1'b1);

      // The largest length opens a unit that never completes.
      reach_unit_boundary();
      send_word(32'hFFFF_FFFF);
      repeat (6) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
      req_valid <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb_length_prefix_deframer_unit: done, clean");
      else
         $display("tb_length_prefix_deframer_unit: done, errors");
      $finish;
   end

endmodule
